@@ sv/sssc_pkg.sv @@
// shared types, codes and constants for the seven-segment scroll scanner
// no dependencies; imported by the interfaces and every module of the block but the text buffer
package sssc_pkg;

  // default sizes, handed down to the top level parameters
  localparam int unsigned DIGITS_DEF    = 4;
  localparam int unsigned BUF_DEPTH_DEF = 64;

  // fixed field widths
  localparam int unsigned OP_W       = 2;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned PAT_W      = 8;
  localparam int unsigned ACT_W      = 2;
  localparam int unsigned DSEL_W     = 2;
  localparam int unsigned DWELL_W    = 16;
  localparam int unsigned BDIG_W     = 3;
  localparam int unsigned TLEN_W     = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // register reset values
  localparam logic [DWELL_W-1:0] DWELL_RST = DWELL_W'(10);
  localparam logic [TLEN_W-1:0]  TLEN_RST  = TLEN_W'(4);

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_STOP  = 2'd2,
    OP_START = 2'd3
  } opcode_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE  = 2'd0,
    ACT_OFF   = 2'd1,
    ACT_DRIVE = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DWELL_COUNT  = 3'd0,
    REG_BLINK_ENABLE = 3'd1,
    REG_BLINK_DIGIT  = 3'd2,
    REG_RUN_ONCE     = 3'd3,
    REG_TEXT_LENGTH  = 3'd4
  } reg_index_t;

  // configuration register contents
  typedef struct packed {
    logic [DWELL_W-1:0] dwell_count;
    logic               blink_enable;
    logic [BDIG_W-1:0]  blink_digit;
    logic               run_once;
    logic [TLEN_W-1:0]  text_length;
  } cfg_t;

  // result of one item, minus the segment pattern read from the buffer
  typedef struct packed {
    action_t           action;
    logic [DSEL_W-1:0] digit_select;
    logic              ok;
    logic              ready_res;
  } res_t;

endpackage

@@ sv/sssc_if.sv @@
// valid/ready channel interfaces: command input, result output, register writes
// depends on sssc_pkg for field widths
interface sssc_in_if;
  import sssc_pkg::*;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [IDX_W-1:0] entry_index;
  logic [PAT_W-1:0] entry_pattern;
  modport source (output valid, output opcode, output entry_index, output entry_pattern,
                  input ready);
  modport sink (input valid, input opcode, input entry_index, input entry_pattern,
                output ready);
endinterface

interface sssc_out_if;
  import sssc_pkg::*;
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [DSEL_W-1:0] digit_select;
  logic [PAT_W-1:0]  segments;
  logic              ok;
  logic              ready_res;
  modport source (output valid, output action, output digit_select, output segments,
                  output ok, output ready_res, input ready);
  modport sink (input valid, input action, input digit_select, input segments,
                input ok, input ready_res, output ready);
endinterface

interface sssc_cfg_if;
  import sssc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output reg_index, output data, input ready);
  modport sink (input valid, input reg_index, input data, output ready);
endinterface

@@ sv/seven_segment_scroll_scanner_top.sv @@
// top level of the seven-segment scroll scanner: output stage and wiring
// depends on sssc_pkg, sssc_if, sssc_cfg_regs, sssc_text_mem, sssc_scan_ctrl
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    opcode, entry_index, entry_pattern
//   out_ch   out  valid/ready    action, digit_select, segments, ok, ready_res
//   cfg_ch   in   valid/ready    reg_index, data (ready always high)
//
// one item per cycle while the sink keeps up; each result shows in the cycle after its
// transfer, the latency of the text buffer read port
// the output register frees in the same cycle it is taken, so input keeps
// flowing while the sink takes every result
// a stalled sink holds the result and blocks the input after one item
// reset is synchronous; the text buffer holds no reset and needs no sweep
module seven_segment_scroll_scanner_top #(
  parameter int unsigned DIGITS    = sssc_pkg::DIGITS_DEF,
  parameter int unsigned BUF_DEPTH = sssc_pkg::BUF_DEPTH_DEF
) (
  input logic          clk,
  input logic          rst_n,
  sssc_in_if.sink      in_ch,
  sssc_out_if.source   out_ch,
  sssc_cfg_if.sink     cfg_ch
);
  import sssc_pkg::*;

  localparam int unsigned ADDR_W = $clog2(BUF_DEPTH);

  cfg_t              cfg;
  res_t              res, res_r;
  logic              fire, out_valid_r;
  logic              mem_wr_en, mem_rd_en;
  logic [ADDR_W-1:0] mem_wr_addr, mem_rd_addr;
  logic [PAT_W-1:0]  mem_rd_data;

  // input handshake
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign fire         = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  sssc_cfg_regs #(.DIGITS(DIGITS)) u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.reg_index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  sssc_scan_ctrl #(
    .DIGITS    (DIGITS),
    .BUF_DEPTH (BUF_DEPTH),
    .ADDR_W    (ADDR_W)
  ) u_scan_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .opcode      (in_ch.opcode),
    .entry_index (in_ch.entry_index),
    .cfg         (cfg),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .res         (res)
  );

  sssc_text_mem #(
    .DEPTH  (BUF_DEPTH),
    .DATA_W (PAT_W),
    .ADDR_W (ADDR_W)
  ) u_text_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (in_ch.entry_pattern),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // output register, valid flag under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) res_r <= res;
  end

  // result fields; segments come from the buffer read register on drive results, else zero
  assign out_ch.valid        = out_valid_r;
  assign out_ch.action       = res_r.action;
  assign out_ch.digit_select = res_r.digit_select;
  assign out_ch.segments     = (res_r.action == ACT_DRIVE) ? mem_rd_data : '0;
  assign out_ch.ok           = res_r.ok;
  assign out_ch.ready_res    = res_r.ready_res;

endmodule

@@ sv/sssc_cfg_regs.sv @@
// configuration register file with write-time clamp of the blink digit
// depends on sssc_pkg (cfg_t, reg_index_t)
module sssc_cfg_regs #(
  parameter int unsigned DIGITS = sssc_pkg::DIGITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [sssc_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [sssc_pkg::CFG_DATA_W-1:0] wr_data,
  output sssc_pkg::cfg_t                  cfg
);
  import sssc_pkg::*;

  cfg_t              cfg_r, cfg_nxt;
  logic [BDIG_W:0]   bdig_ext;

  // blink digit above the digit count is held at the digit count
  assign bdig_ext = {1'b0, wr_data[BDIG_W-1:0]};

  // register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_index_t'(wr_index))
        REG_DWELL_COUNT:  cfg_nxt.dwell_count  = wr_data[DWELL_W-1:0];
        REG_BLINK_ENABLE: cfg_nxt.blink_enable = wr_data[0];
        REG_BLINK_DIGIT: begin
          if (bdig_ext > (BDIG_W+1)'(DIGITS)) cfg_nxt.blink_digit = BDIG_W'(DIGITS);
          else cfg_nxt.blink_digit = wr_data[BDIG_W-1:0];
        end
        REG_RUN_ONCE:     cfg_nxt.run_once     = wr_data[0];
        REG_TEXT_LENGTH:  cfg_nxt.text_length  = wr_data[TLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dwell_count  <= DWELL_RST;
      cfg_r.blink_enable <= 1'b0;
      cfg_r.blink_digit  <= '0;
      cfg_r.run_once     <= 1'b0;
      cfg_r.text_length  <= TLEN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ sv/sssc_text_mem.sv @@
// text buffer: one write port, one read port with registered read data
// no package dependency
module sssc_text_mem #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned DATA_W = 8,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ sv/sssc_scan_ctrl.sv @@
// scan sequencer: digit counter, window position, dwell, edit/blank flags
// depends on sssc_pkg; drives the text buffer ports and the per-item result
module sssc_scan_ctrl #(
  parameter int unsigned DIGITS    = sssc_pkg::DIGITS_DEF,
  parameter int unsigned BUF_DEPTH = sssc_pkg::BUF_DEPTH_DEF,
  parameter int unsigned ADDR_W    = $clog2(BUF_DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        fire,
  input  logic [sssc_pkg::OP_W-1:0]   opcode,
  input  logic [sssc_pkg::IDX_W-1:0]  entry_index,
  input  sssc_pkg::cfg_t              cfg,
  output logic                        mem_wr_en,
  output logic [ADDR_W-1:0]           mem_wr_addr,
  output logic                        mem_rd_en,
  output logic [ADDR_W-1:0]           mem_rd_addr,
  output sssc_pkg::res_t              res
);
  import sssc_pkg::*;

  localparam int unsigned DC_RAW = $clog2(DIGITS + 1);
  localparam int unsigned DC_W   = (DC_RAW > DSEL_W) ? DC_RAW : DSEL_W;
  localparam int unsigned PS_RAW = $clog2(BUF_DEPTH + DIGITS + 1);
  localparam int unsigned POS_W  = (PS_RAW > TLEN_W) ? PS_RAW : TLEN_W;
  localparam int unsigned BCMP_W = (DC_W > BDIG_W) ? DC_W + 1 : BDIG_W + 1;

  logic [DC_W-1:0]    dc_r, dc_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [DWELL_W-1:0] dwell_r, dwell_nxt;
  logic               editing_r, editing_nxt;
  logic               first_pass_r, first_pass_nxt;
  logic               blank_r, blank_nxt;

  logic [POS_W-1:0]   len_raw, eff_len, rewound, idx_ext, rd_pos;
  logic [BCMP_W-1:0]  bd;
  logic               blink_hit, show, rd_req;

  // effective text length, clamped to the display and the buffer
  always_comb begin
    len_raw = POS_W'(cfg.text_length);
    if (len_raw < POS_W'(DIGITS)) eff_len = POS_W'(DIGITS);
    else if (len_raw > POS_W'(BUF_DEPTH)) eff_len = POS_W'(BUF_DEPTH);
    else eff_len = len_raw;
  end

  // window rewind saturating at zero
  assign rewound = (pos_r >= POS_W'(DIGITS)) ? pos_r - POS_W'(DIGITS) : '0;

  // blink selection, single-digit blink dropped for scrolling text
  always_comb begin
    bd = (eff_len > POS_W'(DIGITS)) ? '0 : BCMP_W'(cfg.blink_digit);
    blink_hit = cfg.blink_enable &&
                ((bd == '0) || (BCMP_W'(dc_r) == bd - BCMP_W'(1)));
    show = !blink_hit || (dwell_r >= (cfg.dwell_count >> 1));
  end

  // position stays below twice the depth, so one subtract wraps it
  assign rd_pos = (pos_r >= POS_W'(BUF_DEPTH)) ? pos_r - POS_W'(BUF_DEPTH) : pos_r;
  assign idx_ext = POS_W'(entry_index);

  // per-item next state and result
  always_comb begin
    dc_nxt         = dc_r;
    pos_nxt        = pos_r;
    dwell_nxt      = dwell_r;
    editing_nxt    = editing_r;
    first_pass_nxt = first_pass_r;
    blank_nxt      = blank_r;
    res.action       = ACT_NONE;
    res.digit_select = '0;
    res.ok           = 1'b0;
    rd_req           = 1'b0;
    mem_wr_en        = 1'b0;
    case (opcode_t'(opcode))
      OP_TICK: begin
        if (!editing_r) begin
          if (blank_r) begin
            res.action = ACT_OFF;
          end else if (dc_r >= DC_W'(DIGITS)) begin
            // blanking tick after the last digit
            res.action = ACT_OFF;
            dc_nxt     = '0;
            if (dwell_r != '0) begin
              dwell_nxt = dwell_r - DWELL_W'(1);
              pos_nxt   = rewound;
            end else if (pos_r < eff_len) begin
              pos_nxt   = rewound + POS_W'(1);
              dwell_nxt = cfg.dwell_count;
            end else begin
              first_pass_nxt = 1'b0;
              pos_nxt        = '0;
              if (cfg.run_once) blank_nxt = 1'b1;
              else dwell_nxt = cfg.dwell_count;
            end
          end else begin
            if (show) begin
              res.action       = ACT_DRIVE;
              res.digit_select = dc_r[DSEL_W-1:0];
              rd_req           = 1'b1;
            end else begin
              res.action = ACT_OFF;
            end
            dc_nxt  = dc_r + DC_W'(1);
            pos_nxt = pos_r + POS_W'(1);
          end
        end
      end
      OP_WRITE: begin
        if (editing_r && (idx_ext < POS_W'(BUF_DEPTH))) begin
          mem_wr_en = fire;
          res.ok    = 1'b1;
        end
      end
      OP_STOP: begin
        if (!first_pass_r) begin
          editing_nxt    = 1'b1;
          first_pass_nxt = 1'b1;
          dc_nxt         = '0;
          pos_nxt        = '0;
          res.ok         = 1'b1;
        end
      end
      OP_START: begin
        if (editing_r) begin
          editing_nxt = 1'b0;
          blank_nxt   = 1'b0;
          dwell_nxt   = cfg.dwell_count;
          res.ok      = 1'b1;
        end
      end
      default: ;
    endcase
    res.ready_res = !first_pass_nxt;
  end

  // buffer access; writes happen only while editing and reads only while
  // running, with a start transfer between, so the ports never collide
  assign mem_wr_addr = idx_ext[ADDR_W-1:0];
  assign mem_rd_en   = fire && rd_req;
  assign mem_rd_addr = rd_pos[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_r         <= '0;
      pos_r        <= '0;
      dwell_r      <= '0;
      editing_r    <= 1'b0;
      first_pass_r <= 1'b0;
      blank_r      <= 1'b1;
    end else if (fire) begin
      dc_r         <= dc_nxt;
      pos_r        <= pos_nxt;
      dwell_r      <= dwell_nxt;
      editing_r    <= editing_nxt;
      first_pass_r <= first_pass_nxt;
      blank_r      <= blank_nxt;
    end
  end

endmodule

@@ sv/sssc_checker.sv @@
// port-level checks for the seven-segment scroll scanner, bound to the top
// depends on sssc_pkg and seven_segment_scroll_scanner_top
module sssc_checker #(
  parameter int unsigned DIGITS = sssc_pkg::DIGITS_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [sssc_pkg::ACT_W-1:0]  action,
  input logic [sssc_pkg::DSEL_W-1:0] digit_select,
  input logic [sssc_pkg::PAT_W-1:0]  segments,
  input logic                        ok
);
  import sssc_pkg::*;

  // every input transfer yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("no result after input transfer");

  // a taken result with no new transfer must not show again
  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !(in_valid && in_ready)) |=> !out_valid)
    else $error("result repeated");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(action) &&
      $stable(digit_select) && $stable(segments) && $stable(ok)))
    else $error("stalled result changed");

  // accepted commands never drive the display; driven digit exists
  a_ok_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (action == ACT_DRIVE)) |->
      (!ok && (32'(digit_select) < DIGITS)))
    else $error("bad drive result");

endmodule

bind seven_segment_scroll_scanner_top sssc_checker #(.DIGITS(DIGITS)) u_sssc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .action       (out_ch.action),
  .digit_select (out_ch.digit_select),
  .segments     (out_ch.segments),
  .ok           (out_ch.ok)
);

@@ dv/seven_segment_scroll_scanner_top_tb.sv @@
// testbench for seven_segment_scroll_scanner_top: directed and random command streams,
// results checked against an in-bench model of the scanner, random stalls on both sides
// depends on sssc_pkg, the channel interfaces in sssc_if and the block's rtl
module seven_segment_scroll_scanner_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sssc_pkg::*;

  localparam int unsigned NDIG         = DIGITS_DEF;
  localparam int unsigned DEPTH        = BUF_DEPTH_DEF;
  localparam int unsigned RAND_ITEMS   = 1200;
  localparam int unsigned NUM_PHASES   = 8;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 4;

  // one expected or observed result
  typedef struct packed {
    action_t           action;
    logic [DSEL_W-1:0] digit_select;
    logic [PAT_W-1:0]  segments;
    logic              ok;
    logic              ready_res;
  } scan_result_t;

  // model of the scanner plus the queue of results it still owes
  class scan_scoreboard;
    logic [DWELL_W-1:0] dwell_count;
    logic               blink_enable;
    logic [BDIG_W-1:0]  blink_digit;
    logic               run_once;
    logic [TLEN_W-1:0]  text_length;
    logic [PAT_W-1:0]   text_buf [DEPTH];
    bit                 written [DEPTH];
    logic [2:0]         digit_cnt;
    logic [TLEN_W-1:0]  text_pos;
    logic [DWELL_W-1:0] dwell_left;
    bit                 editing;
    bit                 first_pass;
    bit                 blank_mode;
    scan_result_t       due_q [$];
    int unsigned        mismatches, checked, drives, passes, writes;

    function new();
      dwell_count  = DWELL_RST;
      blink_enable = 1'b0;
      blink_digit  = '0;
      run_once     = 1'b0;
      text_length  = TLEN_RST;
      digit_cnt    = '0;
      text_pos     = '0;
      dwell_left   = '0;
      editing      = 1'b0;
      first_pass   = 1'b0;
      blank_mode   = 1'b1;
      foreach (text_buf[i]) begin
        text_buf[i] = '0;
        written[i]  = 1'b0;
      end
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DWELL_COUNT:  dwell_count = data[DWELL_W-1:0];
        REG_BLINK_ENABLE: blink_enable = data[0];
        REG_BLINK_DIGIT:  blink_digit = (data[BDIG_W-1:0] > NDIG) ? BDIG_W'(NDIG)
                                                                   : data[BDIG_W-1:0];
        REG_RUN_ONCE:     run_once = data[0];
        REG_TEXT_LENGTH:  text_length = data[TLEN_W-1:0];
        default: ;
      endcase
    endfunction

    // length as the scanner uses it
    function int unsigned eff_of(int unsigned v);
      if (v < NDIG) return NDIG;
      if (v > DEPTH) return DEPTH;
      return v;
    endfunction

    function int unsigned text_span();
      return eff_of(text_length);
    endfunction

    // entries written without a hole, counted from index 0
    function int unsigned written_run();
      int unsigned n;
      n = 0;
      while (n < DEPTH && written[n]) n++;
      return n;
    endfunction

    function logic [TLEN_W-1:0] rewind(logic [TLEN_W-1:0] p);
      return (p >= NDIG) ? p - TLEN_W'(NDIG) : '0;
    endfunction

    // predict one accepted command; returns 1 unless the block just ignores it
    function bit note_command(opcode_t op, logic [IDX_W-1:0] idx, logic [PAT_W-1:0] pat);
      scan_result_t r;
      int unsigned  len;
      logic [BDIG_W-1:0] bd;
      bit acted;
      r        = '0;
      r.action = ACT_NONE;
      len      = text_span();
      acted    = 1'b0;
      case (op)
        OP_TICK: begin
          if (!editing) begin
            acted = 1'b1;
            if (blank_mode) begin
              r.action = ACT_OFF;
            end else if (digit_cnt >= NDIG) begin
              // blanking slot after the last digit: repeat, scroll or finish the pass
              r.action = ACT_OFF;
              if (dwell_left > 0) begin
                dwell_left--;
                digit_cnt = '0;
                text_pos  = rewind(text_pos);
              end else if (text_pos < len) begin
                text_pos   = rewind(text_pos) + 1'b1;
                digit_cnt  = '0;
                dwell_left = dwell_count;
              end else begin
                first_pass = 1'b0;
                digit_cnt  = '0;
                text_pos   = '0;
                passes++;
                if (run_once) blank_mode = 1'b1;
                else dwell_left = dwell_count;
              end
            end else begin
              // single-digit blink only applies when the text fits the display
              bd = (len > NDIG) ? '0 : blink_digit;
              if (blink_enable && (bd == 0 || digit_cnt == bd - 1) &&
                  dwell_left < dwell_count / 2) begin
                r.action = ACT_OFF;
              end else begin
                r.action       = ACT_DRIVE;
                r.digit_select = digit_cnt[DSEL_W-1:0];
                r.segments     = text_buf[text_pos % DEPTH];
                drives++;
              end
              digit_cnt++;
              text_pos++;
            end
          end
        end
        OP_WRITE: begin
          if (editing) begin
            text_buf[idx] = pat;
            written[idx]  = 1'b1;
            r.ok          = 1'b1;
            writes++;
          end
        end
        OP_STOP: begin
          if (!first_pass) begin
            editing    = 1'b1;
            first_pass = 1'b1;
            digit_cnt  = '0;
            text_pos   = '0;
            r.ok       = 1'b1;
          end
        end
        default: begin
          if (editing) begin
            editing    = 1'b0;
            blank_mode = 1'b0;
            dwell_left = dwell_count;
            r.ok       = 1'b1;
          end
        end
      endcase
      r.ready_res = !first_pass;
      due_q.push_back(r);
      return acted || r.ok;
    endfunction

    function void report(string field, logic [PAT_W-1:0] want, logic [PAT_W-1:0] got);
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      mismatches++;
    endfunction

    // compare one result transfer with the oldest expectation
    function void check_result(scan_result_t got);
      scan_result_t want;
      if (due_q.size() == 0) begin
        $display({"%0t: result with nothing expected, ",
                  "got action %0h digit %0h seg %0h ok %0h rdy %0h"},
                 $time, got.action, got.digit_select, got.segments, got.ok, got.ready_res);
        mismatches++;
        return;
      end
      want = due_q.pop_front();
      checked++;
      if (got.action !== want.action) report("action", want.action, got.action);
      if (got.digit_select !== want.digit_select)
        report("digit_select", want.digit_select, got.digit_select);
      if (got.segments !== want.segments) report("segments", want.segments, got.segments);
      if (got.ok !== want.ok) report("ok", want.ok, got.ok);
      if (got.ready_res !== want.ready_res) report("ready_res", want.ready_res, got.ready_res);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  sssc_in_if  cmd_ch ();
  sssc_out_if res_ch ();
  sssc_cfg_if reg_ch ();

  seven_segment_scroll_scanner_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_ch),
    .out_ch (res_ch),
    .cfg_ch (reg_ch)
  );

  scan_scoreboard scan_sb = new();
  int unsigned    tx_idle_pct = 0;
  int unsigned    rx_idle_pct = 0;
  bit             hold_req = 1'b0;
  int unsigned    sent = 0;

  // clock
  always #5 clk = ~clk;

  // watchdog
  initial begin
    #5_000_000;
    $display("seven_segment_scroll_scanner_top_tb failed");
    $finish;
  end

  // result side: check each transfer, stall at random or for one long hold-off
  initial begin
    scan_result_t seen;
    int unsigned  hold_left;
    hold_left    = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && res_ch.valid && res_ch.ready) begin
        seen.action       = action_t'(res_ch.action);
        seen.digit_select = res_ch.digit_select;
        seen.segments     = res_ch.segments;
        seen.ok           = res_ch.ok;
        seen.ready_res    = res_ch.ready_res;
        scan_sb.check_result(seen);
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // one command transfer, after an optional random gap
  task automatic send_command(input opcode_t op, input logic [IDX_W-1:0] idx,
                              input logic [PAT_W-1:0] pat, output bit acted);
    while ($urandom_range(99) < tx_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    if (!cmd_ch.valid) cmd_ch.valid <= 1'b1;
    cmd_ch.opcode        <= op;
    cmd_ch.entry_index   <= idx;
    cmd_ch.entry_pattern <= pat;
    do @(posedge clk); while (!cmd_ch.ready);
    acted = scan_sb.note_command(op, idx, pat);
    sent++;
  endtask

  // register write; the caller lowers valid after the last one
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    if (!reg_ch.valid) reg_ch.valid <= 1'b1;
    reg_ch.reg_index <= idx;
    reg_ch.data      <= data;
    do @(posedge clk); while (!reg_ch.ready);
    scan_sb.set_register(idx, data);
  endtask

  // register value with random junk above the field half of the time
  function automatic logic [CFG_DATA_W-1:0] with_noise(input int unsigned v,
                                                       input int unsigned w);
    logic [CFG_DATA_W-1:0] hi;
    hi = $urandom_range(1) ? CFG_DATA_W'($urandom) : '0;
    return (hi << w) | CFG_DATA_W'(v);
  endfunction

  // wait until every expected result has come back, then let the pipe settle
  task automatic settle();
    while (scan_sb.due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register setting per phase; text length kept within the loaded text
  task automatic configure(input int unsigned ph);
    int unsigned dwell, tlen, limit_len;
    dwell = (ph == NUM_PHASES - 1) ? 16'hFFFF : (ph == 0) ? 0 : $urandom_range(1, 3);
    case (ph)
      0:       tlen = 4;
      1:       tlen = 3;
      2:       tlen = 0;
      3:       tlen = $urandom_range(5, 12);
      4:       tlen = 64;
      5:       tlen = $urandom_range(65, 127);
      6:       tlen = $urandom_range(4, 40);
      default: tlen = 127;
    endcase
    limit_len = (scan_sb.written_run() < NDIG) ? NDIG : scan_sb.written_run();
    if (scan_sb.eff_of(tlen) > limit_len) tlen = limit_len;
    write_register(REG_DWELL_COUNT, CFG_DATA_W'(dwell));
    write_register(REG_BLINK_ENABLE, with_noise(ph % 3 != 0, 1));
    write_register(REG_BLINK_DIGIT,
                   with_noise((ph == 1) ? 0 : (ph == 2) ? $urandom_range(1, NDIG)
                                                        : $urandom_range(0, 7), BDIG_W));
    write_register(REG_RUN_ONCE, with_noise(ph == 2 || ph == 5, 1));
    write_register(REG_TEXT_LENGTH, with_noise(tlen, TLEN_W));
    // an index past the register list must change nothing
    write_register(CFG_IDX_W'($urandom_range(int'(REG_TEXT_LENGTH) + 1, (1 << CFG_IDX_W) - 1)),
                   CFG_DATA_W'($urandom));
    reg_ch.valid <= 1'b0;
  endtask

  // mostly well-formed edit/run cycles, with some refused or ignored commands
  task automatic pick_command(output opcode_t op, output logic [IDX_W-1:0] idx,
                              output logic [PAT_W-1:0] pat);
    int unsigned r, span;
    r    = $urandom_range(99);
    span = scan_sb.written_run();
    idx  = IDX_W'($urandom_range(DEPTH - 1));
    pat  = PAT_W'($urandom_range(255));
    if (scan_sb.editing) begin
      if (r < ((span < DEPTH) ? 5 : 12)) op = OP_START;
      else if (r < 16) op = OP_TICK;
      else if (r < 19) op = OP_STOP;
      else begin
        op = OP_WRITE;
        if (r < 80 && span < DEPTH) idx = IDX_W'(span);
      end
      // never run a text that has holes in it
      if (op == OP_START && span < scan_sb.text_span()) begin
        op  = OP_WRITE;
        idx = IDX_W'(span);
      end
    end else begin
      if (r < 86) op = OP_TICK;
      else if (r < 93) op = OP_STOP;
      else if (r < 96) op = OP_WRITE;
      else op = OP_START;
    end
  endtask

  // main sequence
  initial begin
    logic [PAT_W-1:0] seed_pats [4] = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
    opcode_t          op;
    logic [IDX_W-1:0] idx;
    logic [PAT_W-1:0] pat;
    bit               acted;
    int unsigned      counted;

    rst_n                = 1'b0;
    cmd_ch.valid         = 1'b0;
    cmd_ch.opcode        = OP_TICK;
    cmd_ch.entry_index   = '0;
    cmd_ch.entry_pattern = '0;
    reg_ch.valid         = 1'b0;
    reg_ch.reg_index     = REG_DWELL_COUNT;
    reg_ch.data          = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: short dwell so one pass fits in a few ticks
    write_register(REG_DWELL_COUNT, CFG_DATA_W'(1));
    reg_ch.valid <= 1'b0;
    @(posedge clk);
    send_command(OP_TICK, '0, '0, acted);             // blank after reset
    send_command(OP_WRITE, '1, '1, acted);            // write outside editing
    send_command(OP_START, '0, '0, acted);            // start outside editing
    send_command(OP_STOP, '0, '0, acted);
    send_command(OP_STOP, '1, '0, acted);             // stop during first pass
    send_command(OP_TICK, '1, '1, acted);             // tick while editing
    for (int i = 0; i < NDIG; i++) send_command(OP_WRITE, IDX_W'(i), seed_pats[i], acted);
    send_command(OP_WRITE, '1, 8'h81, acted);         // last buffer entry
    send_command(OP_START, '0, '0, acted);
    for (int i = 0; i < 2 * (NDIG + 1); i++) send_command(OP_TICK, '0, '0, acted);
    send_command(OP_STOP, '0, '0, acted);             // pass done, stop accepted
    cmd_ch.valid <= 1'b0;

    // random phases under changing settings and idling
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      tx_idle_pct = (ph < 3) ? 30 : (ph < 6) ? 65 : 0;
      rx_idle_pct = (ph < 3) ? 65 : (ph < 6) ? 30 : 0;
      configure(ph);
      if (ph == 6) hold_req = 1'b1;
      counted = 0;
      while (counted < RAND_ITEMS / NUM_PHASES) begin
        pick_command(op, idx, pat);
        send_command(op, idx, pat, acted);
        if (acted) counted++;
      end
      cmd_ch.valid <= 1'b0;
    end
    settle();

    $display({"sent %0d commands under %0d register settings: ",
              "%0d digit drives, %0d text writes, %0d passes"},
             sent, NUM_PHASES + 1, scan_sb.drives, scan_sb.writes, scan_sb.passes);
    $display("compared %0d results, %0d mismatches", scan_sb.checked, scan_sb.mismatches);
    if (scan_sb.mismatches == 0 && scan_sb.due_q.size() == 0) begin
      $display("seven_segment_scroll_scanner_top_tb passed");
    end else begin
      $display("seven_segment_scroll_scanner_top_tb failed");
    end
    $finish;
  end

endmodule
